// ----- hdl/tkpm_pkg.sv -----
// Shared types, constants and packing helpers for the top-k peak list merge block.
package tkpm_pkg;

   localparam int TOP_COUNT = 5;
   localparam int VALUE_W   = 32;
   localparam int BIN_W     = 10;
   localparam int IDX_W     = $clog2(TOP_COUNT + 1);

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [BIN_W-1:0]   bin;
   } entry_type;

   typedef entry_type [TOP_COUNT-1:0] list_type;

   typedef struct packed {
      logic               axis;
      logic [VALUE_W-1:0] peak0_value;
      logic [VALUE_W-1:0] peak1_value;
      logic [VALUE_W-1:0] peak2_value;
      logic [VALUE_W-1:0] peak3_value;
      logic [VALUE_W-1:0] peak4_value;
      logic [BIN_W-1:0]   peak0_bin;
      logic [BIN_W-1:0]   peak1_bin;
      logic [BIN_W-1:0]   peak2_bin;
      logic [BIN_W-1:0]   peak3_bin;
      logic [BIN_W-1:0]   peak4_bin;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0] top0_value;
      logic [VALUE_W-1:0] top1_value;
      logic [VALUE_W-1:0] top2_value;
      logic [VALUE_W-1:0] top3_value;
      logic [VALUE_W-1:0] top4_value;
      logic [BIN_W-1:0]   top0_bin;
      logic [BIN_W-1:0]   top1_bin;
      logic [BIN_W-1:0]   top2_bin;
      logic [BIN_W-1:0]   top3_bin;
      logic [BIN_W-1:0]   top4_bin;
   } rsp_payload_type;

   // Command to the shared compare-and-insert unit.
   typedef struct packed {
      logic [VALUE_W-1:0] opa;
      logic [VALUE_W-1:0] opb;
      logic [IDX_W-1:0]   pos;
      entry_type          entry;
   } cmp_cmd_type;

   function automatic list_type unpack_req(input req_payload_type r);
      list_type l;
      l[0] = '{value: r.peak0_value, bin: r.peak0_bin};
      l[1] = '{value: r.peak1_value, bin: r.peak1_bin};
      l[2] = '{value: r.peak2_value, bin: r.peak2_bin};
      l[3] = '{value: r.peak3_value, bin: r.peak3_bin};
      l[4] = '{value: r.peak4_value, bin: r.peak4_bin};
      return l;
   endfunction

   function automatic rsp_payload_type pack_rsp(input list_type l);
      rsp_payload_type p;
      p.top0_value = l[0].value;
      p.top1_value = l[1].value;
      p.top2_value = l[2].value;
      p.top3_value = l[3].value;
      p.top4_value = l[4].value;
      p.top0_bin   = l[0].bin;
      p.top1_bin   = l[1].bin;
      p.top2_bin   = l[2].bin;
      p.top3_bin   = l[3].bin;
      p.top4_bin   = l[4].bin;
      return p;
   endfunction

endpackage

// ----- hdl/tkpm_cmp_unit.sv -----
// Shared unsigned compare and list insert unit used by every merge step.
module tkpm_cmp_unit
   import tkpm_pkg::*;
(
   input  cmp_cmd_type cmd,
   input  list_type    list_i,
   output logic        gt,
   output list_type    list_o
);

   assign gt = (cmd.opa > cmd.opb);

   // Place the entry at pos, shift the tail down, drop the last one.
   always_comb begin
      for (int k = 0; k < TOP_COUNT; k++) begin
         if (IDX_W'(k) < cmd.pos) begin
            list_o[k] = list_i[k];
         end else if (IDX_W'(k) == cmd.pos) begin
            list_o[k] = cmd.entry;
         end else begin
            list_o[k] = list_i[(k > 0) ? k - 1 : 0];
         end
      end
   end

endmodule

// ----- hdl/top_k_peak_list_merge_top.sv -----
// Top level of the top-k peak list merge block: sequencer, list store, result register.
// Steps: replace = top check, writeback; unchanged = both checks, writeback; merge = both
//   checks, one compare per stored position, writeback; bad axis = writeback only.
// Flow: no new item is taken until the last is written back (single shared comparator);
//   req_stall is high while an item is at work and writeback waits on a stall.
// Reset: synchronous, active high; clears every stored list and empties the result register.
module top_k_peak_list_merge_top
   import tkpm_pkg::*;
#(
   parameter int AXIS_COUNT = 2
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   localparam int AXIS_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHK_TOP = 3'd1;
   localparam logic [2:0] S_CHK_LOW = 3'd2;
   localparam logic [2:0] S_MERGE   = 3'd3;
   localparam logic [2:0] S_WRITE   = 3'd4;

   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TOP_COUNT);

   // Stored lists, one per axis.
   list_type              store_ff [AXIS_COUNT];

   logic [2:0]            state_ff, state_in;
   list_type              work_ff, work_in;      // list being merged
   list_type              new_ff;                // incoming peaks
   logic [AXIS_W-1:0]     axis_ff;
   logic                  axis_ok_ff;
   logic [IDX_W-1:0]      i_ff, i_in;            // next new peak to place
   logic [IDX_W-1:0]      j_ff, j_in;            // next stored position to try
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff;

   cmp_cmd_type           cmd;
   logic                  gt;
   list_type              ins_list;

   logic                  req_xfer;
   logic                  rsp_free;
   logic                  req_axis_ok;
   logic [IDX_W-1:0]      i_step, j_step;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_xfer    = req_valid && !req_stall;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign req_axis_ok = (32'(req_data.axis) < AXIS_COUNT);

   tkpm_cmp_unit u_cmp (
      .cmd    (cmd),
      .list_i (work_ff),
      .gt     (gt),
      .list_o (ins_list)
   );

   assign i_step = IDX_W'(i_ff + IDX_W'(1));
   assign j_step = IDX_W'(j_ff + IDX_W'(1));

   // Route operands to the shared comparator by state and step the sequencer.
   always_comb begin
      state_in       = state_ff;
      work_in        = work_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      cmd.opa        = new_ff[0].value;
      cmd.opb        = work_ff[TOP_COUNT-1].value;
      cmd.pos        = j_ff;
      cmd.entry      = new_ff[0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               // Load the stored list of the addressed axis.
               work_in  = store_ff[AXIS_W'(req_data.axis)];
               state_in = req_axis_ok ? S_CHK_TOP : S_WRITE;
            end
         end
         S_CHK_TOP: begin
            // Stored top not above the new lowest: replace whole.
            cmd.opa = work_ff[0].value;
            cmd.opb = new_ff[TOP_COUNT-1].value;
            if (gt) begin
               state_in = S_CHK_LOW;
            end else begin
               work_in  = new_ff;
               state_in = S_WRITE;
            end
         end
         S_CHK_LOW: begin
            // Merge only when the new top beats the stored lowest.
            cmd.opa = new_ff[0].value;
            cmd.opb = work_ff[TOP_COUNT-1].value;
            i_in    = '0;
            j_in    = '0;
            state_in = gt ? S_MERGE : S_WRITE;
         end
         S_MERGE: begin
            cmd.opa   = new_ff[i_ff].value;
            cmd.opb   = work_ff[j_ff].value;
            cmd.entry = new_ff[i_ff];
            j_in      = j_step;
            if (gt) begin
               work_in = ins_list;
               i_in    = i_step;
            end
            // Stop when the stored positions or the new peaks run out.
            if ((j_step == LAST_POS) || (gt && (i_step == LAST_POS))) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         for (int a = 0; a < AXIS_COUNT; a++) begin
            store_ff[a] <= '0;
         end
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         // Drop the result once taken; a new one replaces it at writeback.
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if ((state_ff == S_WRITE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            if (axis_ok_ff) begin
               store_ff[axis_ff] <= work_ff;
            end
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (req_xfer) begin
         new_ff     <= unpack_req(req_data);
         axis_ff    <= AXIS_W'(req_data.axis);
         axis_ok_ff <= req_axis_ok;
      end
      if ((state_ff == S_WRITE) && rsp_free) begin
         rsp_data_ff <= axis_ok_ff ? pack_rsp(work_ff) : '0;
      end
   end

endmodule

// ----- hdl/tkpm_checker.sv -----
// Port-level assertions for the top-k peak list merge block, with its bind.
module tkpm_checker
   import tkpm_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Stall the input while an accepted item is at work.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after a transfer");

   // A fresh result appears only as the sequencer returns to idle.
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result raised while sequencer busy");

endmodule

bind top_k_peak_list_merge_top tkpm_checker u_tkpm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- verif/top_k_peak_list_merge_top_tb.sv -----
// Self-checking testbench for the top-k peak list merge block.
`timescale 1ns / 1ps

module top_k_peak_list_merge_top_tb;
   import tkpm_pkg::*;

   localparam int NUM_AXES = 2;
   localparam int RANDOM_ITEMS = 1200;
   localparam logic [VALUE_W-1:0] MID = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   // Ways of building a random peak list.
   typedef enum int {
      PEAKS_FULL,
      PEAKS_TIED,
      PEAKS_NEAR_MAX,
      PEAKS_NEAR_STORED,
      PEAKS_UNSORTED
   } peak_mode_type;

   // Receiver back-pressure patterns.
   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_RUNS
   } stall_mode_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   // Shadow copy of both stored peak lists.
   logic [VALUE_W-1:0] stored_value [NUM_AXES][TOP_COUNT];
   logic [BIN_W-1:0]   stored_bin   [NUM_AXES][TOP_COUNT];

   // Lists the block still owes, oldest first.
   rsp_payload_type pending_tops [$];

   int             error_count = 0;
   int             burst_left = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   always #10 clock = ~clock;

   top_k_peak_list_merge_top #(
      .AXIS_COUNT(NUM_AXES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Merge one new peak list into the shadow store and return the updated list.
   function automatic rsp_payload_type merge_peaks(input req_payload_type p);
      logic [VALUE_W-1:0] nv [TOP_COUNT];
      logic [BIN_W-1:0]   nb [TOP_COUNT];
      list_type           merged;
      int                 ax;
      int                 start;
      bit                 placed;
      bit                 done;

      ax = int'(p.axis);
      // Out-of-range axis: store nothing, report an all-zero list.
      if (ax >= NUM_AXES) begin
         return '0;
      end
      nv[0] = p.peak0_value; nb[0] = p.peak0_bin;
      nv[1] = p.peak1_value; nb[1] = p.peak1_bin;
      nv[2] = p.peak2_value; nb[2] = p.peak2_bin;
      nv[3] = p.peak3_value; nb[3] = p.peak3_bin;
      nv[4] = p.peak4_value; nb[4] = p.peak4_bin;

      if (stored_value[ax][0] <= nv[TOP_COUNT-1]) begin
         // Whole new list dominates: replace.
         for (int k = 0; k < TOP_COUNT; k++) begin
            stored_value[ax][k] = nv[k];
            stored_bin[ax][k]   = nb[k];
         end
      end else if (stored_value[ax][TOP_COUNT-1] < nv[0]) begin
         // Insert in order; a tie goes behind the stored entry.
         start = 0;
         done  = 1'b0;
         for (int i = 0; i < TOP_COUNT; i++) begin
            placed = 1'b0;
            if (!done) begin
               for (int j = 0; j < TOP_COUNT; j++) begin
                  if (!placed && j >= start && nv[i] > stored_value[ax][j]) begin
                     for (int k = TOP_COUNT - 1; k > j; k--) begin
                        stored_value[ax][k] = stored_value[ax][k-1];
                        stored_bin[ax][k]   = stored_bin[ax][k-1];
                     end
                     stored_value[ax][j] = nv[i];
                     stored_bin[ax][j]   = nb[i];
                     start  = j + 1;
                     placed = 1'b1;
                  end
               end
               if (!placed) begin
                  done = 1'b1;
               end
            end
         end
      end

      for (int k = 0; k < TOP_COUNT; k++) begin
         merged[k].value = stored_value[ax][k];
         merged[k].bin   = stored_bin[ax][k];
      end
      return pack_list(merged);
   endfunction

   function automatic rsp_payload_type pack_list(input list_type l);
      rsp_payload_type r;
      r.top0_value = l[0].value; r.top0_bin = l[0].bin;
      r.top1_value = l[1].value; r.top1_bin = l[1].bin;
      r.top2_value = l[2].value; r.top2_bin = l[2].bin;
      r.top3_value = l[3].value; r.top3_bin = l[3].bin;
      r.top4_value = l[4].value; r.top4_bin = l[4].bin;
      return r;
   endfunction

   function automatic list_type unpack_list(input rsp_payload_type r);
      list_type l;
      l[0] = '{value: r.top0_value, bin: r.top0_bin};
      l[1] = '{value: r.top1_value, bin: r.top1_bin};
      l[2] = '{value: r.top2_value, bin: r.top2_bin};
      l[3] = '{value: r.top3_value, bin: r.top3_bin};
      l[4] = '{value: r.top4_value, bin: r.top4_bin};
      return l;
   endfunction

   // Five values with consecutive bins starting at bin_base.
   function automatic list_type make_list(input logic [VALUE_W-1:0] v0, v1, v2, v3, v4,
                                          input logic [BIN_W-1:0] bin_base);
      list_type l;
      l[0] = '{value: v0, bin: bin_base};
      l[1] = '{value: v1, bin: bin_base + 10'd1};
      l[2] = '{value: v2, bin: bin_base + 10'd2};
      l[3] = '{value: v3, bin: bin_base + 10'd3};
      l[4] = '{value: v4, bin: bin_base + 10'd4};
      return l;
   endfunction

   function automatic list_type sort_descending(input list_type l);
      entry_type t;
      for (int i = 0; i < TOP_COUNT - 1; i++) begin
         for (int j = 0; j < TOP_COUNT - 1 - i; j++) begin
            if (l[j].value < l[j+1].value) begin
               t      = l[j];
               l[j]   = l[j+1];
               l[j+1] = t;
            end
         end
      end
      return l;
   endfunction

   function automatic list_type random_peaks(input logic axis, input peak_mode_type mode);
      list_type           l;
      logic [VALUE_W-1:0] base;
      base = stored_value[axis][$urandom_range(0, TOP_COUNT - 1)];
      for (int k = 0; k < TOP_COUNT; k++) begin
         l[k].bin = BIN_W'($urandom_range(0, 1023));
         case (mode)
            PEAKS_TIED:        l[k].value = VALUE_W'($urandom_range(0, 7));
            PEAKS_NEAR_MAX:    l[k].value = ALL_ONES - VALUE_W'($urandom_range(0, 255));
            PEAKS_NEAR_STORED: l[k].value = base + VALUE_W'($urandom_range(0, 4)) - 32'd2;
            default:           l[k].value = $urandom;
         endcase
      end
      return (mode == PEAKS_UNSORTED) ? l : sort_descending(l);
   endfunction

   // Offer one peak list, idling first when a burst has run out; predict on transfer.
   task automatic send_peaks(input logic axis, input list_type l);
      req_payload_type p;
      int              gap;
      p.axis        = axis;
      p.peak0_value = l[0].value; p.peak0_bin = l[0].bin;
      p.peak1_value = l[1].value; p.peak1_bin = l[1].bin;
      p.peak2_value = l[2].value; p.peak2_bin = l[2].bin;
      p.peak3_value = l[3].value; p.peak3_bin = l[3].bin;
      p.peak4_value = l[4].value; p.peak4_bin = l[4].bin;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= p;
      // Hold the payload until the block takes the transfer.
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_tops.push_back(merge_peaks(p));
   endtask

   // Compare one delivered list against the oldest prediction.
   task automatic check_tops(input rsp_payload_type actual);
      list_type want;
      list_type got;
      if (pending_tops.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %h", $time, actual);
         error_count++;
      end else begin
         want = unpack_list(pending_tops.pop_front());
         got  = unpack_list(actual);
         for (int k = 0; k < TOP_COUNT; k++) begin
            if (got[k].value !== want[k].value) begin
               $display("%0t: top%0d_value expected %h, actual %h",
                        $time, k, want[k].value, got[k].value);
               error_count++;
            end
            if (got[k].bin !== want[k].bin) begin
               $display("%0t: top%0d_bin expected %h, actual %h",
                        $time, k, want[k].bin, got[k].bin);
               error_count++;
            end
         end
      end
   endtask

   // Receiver: check every transfer, then pick the next stall value.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            check_tops(rsp_data);
         end
         if (stall_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 80);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= stall_left[3];
         endcase
      end
   end

   task automatic test_reset_state();
      // Stores start at zero, so an all-zero list replaces (equal top and lowest).
      send_peaks(1'b0, make_list(0, 0, 0, 0, 0, 10'd1019));
      send_peaks(1'b1, make_list(0, 0, 0, 0, 0, 10'd0));
   endtask

   task automatic test_replace();
      send_peaks(1'b0, make_list(500, 400, 300, 200, 100, 10'd20));
      send_peaks(1'b0, make_list(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 10'd0));
   endtask

   task automatic test_unchanged();
      // Stored lowest is not below the new top: no change.
      send_peaks(1'b0, make_list(10, 9, 8, 7, 6, 10'd100));
   endtask

   task automatic test_insert();
      send_peaks(1'b1, make_list(1000, 800, 600, 400, 200, 10'd200));
      send_peaks(1'b1, make_list(900, 700, 500, 300, 100, 10'd300));
      // Only the first peak fits; the rest rank below every stored entry.
      send_peaks(1'b1, make_list(5000, 50, 40, 30, 20, 10'd400));
   endtask

   task automatic test_ties();
      send_peaks(1'b1, make_list(MID + 40, MID + 30, MID + 30, MID + 20, MID + 10, 10'd500));
      send_peaks(1'b1, make_list(MID + 30, MID + 30, MID + 20, MID + 5, MID + 1, 10'd600));
      // Equal to every stored entry: replace on equality.
      send_peaks(1'b0, make_list(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 10'd700));
   endtask

   task automatic test_unsorted();
      send_peaks(1'b1, make_list(MID + 50, MID + 60, 3, MID + 45, 0, 10'd800));
      // Large lowest entry forces a replace with an ascending list.
      send_peaks(1'b1, make_list(1, 2, 3, 4, ALL_ONES, 10'd900));
      send_peaks(1'b1, make_list(7, 2, 9, 0, 1, 10'd950));
   endtask

   task automatic test_extremes();
      send_peaks(1'b0, make_list(0, 0, 0, 0, 0, 10'd1023));
      send_peaks(1'b0, make_list(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF,
                                 32'h0000_00FF, 32'h0000_0001, 10'd1019));
      send_peaks(1'b1, make_list(ALL_ONES, 32'hFFFF_FFFE, MID, 32'h7FFF_FFFF, 0, 10'd1021));
      send_peaks(1'b1, make_list(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 10'd1023));
   endtask

   task automatic test_random();
      logic          axis;
      int            pick;
      peak_mode_type mode;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         axis = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < 30)      mode = PEAKS_FULL;
         else if (pick < 50) mode = PEAKS_TIED;
         else if (pick < 60) mode = PEAKS_NEAR_MAX;
         else if (pick < 92) mode = PEAKS_NEAR_STORED;
         else                mode = PEAKS_UNSORTED;
         send_peaks(axis, random_peaks(axis, mode));
      end
   endtask

   initial begin
      for (int a = 0; a < NUM_AXES; a++) begin
         for (int k = 0; k < TOP_COUNT; k++) begin
            stored_value[a][k] = '0;
            stored_bin[a][k]   = '0;
         end
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_replace();
      test_unchanged();
      test_insert();
      test_ties();
      test_unsorted();
      test_extremes();
      test_random();

      // Drop valid, drain the outstanding lists, then let the pipeline settle.
      req_valid <= 1'b0;
      while (pending_tops.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #(64'd10_000_000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
